// ===== rtl/rvg_pkg.sv =====
package rvg_pkg;

    // Fixed-point layout
    localparam int FRAC_BITS  = 12;
    localparam int GAIN_SHIFT = 12;
    localparam int HEAD_W     = 48;
    localparam int IDX_W      = 36;
    localparam int RATE_W     = 20;
    localparam int GAIN_W     = 16;
    localparam int LEN_W      = 17;
    localparam int SMP_W      = 16;
    localparam int MIX_W      = 24;
    localparam int OUT_W      = 29;
    localparam int SUM_W      = 25;
    localparam int PROD_W     = 42;
    localparam int DIV_CNT_W  = 6;

    // Clip memory
    localparam int CLIP_FRAMES = 65536;
    localparam int CLIP_AW     = 16;
    localparam int FRAME_W     = 2 * SMP_W;

    // Stream and configuration widths
    localparam int IN_DATA_W   = 96;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int PAYLOAD_W   = 48;

    // Request queue
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CNT_W  = 3;

    // Command codes on the input stream
    localparam logic [2:0] CMD_LOAD    = 3'd0;
    localparam logic [2:0] CMD_TICK    = 3'd1;
    localparam logic [2:0] CMD_PLAY    = 3'd2;
    localparam logic [2:0] CMD_RESTART = 3'd3;
    localparam logic [2:0] CMD_PAUSE   = 3'd4;
    localparam logic [2:0] CMD_STOP    = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEN   = 3'd4;

    // Voice play state codes
    localparam logic [1:0] VS_STOPPED = 2'd0;
    localparam logic [1:0] VS_PLAYING = 2'd1;
    localparam logic [1:0] VS_PAUSED  = 2'd2;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_TICK,
        OP_PLAY,
        OP_RESTART,
        OP_PAUSE,
        OP_STOP,
        OP_NONE
    } t_op;

    // Classified request: load carries {right, left, address}, tick carries {mix_r, mix_l}
    typedef struct packed {
        t_op                  op;
        logic [PAYLOAD_W-1:0] payload;
    } t_qent;

    typedef struct packed {
        logic [RATE_W-1:0] step_rate;
        logic [GAIN_W-1:0] left_gain;
        logic [GAIN_W-1:0] right_gain;
        logic              loop_en;
        logic [LEN_W-1:0]  clip_len;
    } t_cfg;

endpackage

// ===== rtl/rvg_ram.sv =====
module rvg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rvg_front.sv =====
module rvg_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rvg_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic [rvg_pkg::IN_USER_W-1:0]   i_s_tuser,
    output logic                            o_q_valid,
    output rvg_pkg::t_qent                  o_q_ent,
    input  logic                            i_q_pop
);

    rvg_pkg::t_qent                    w_ent;
    rvg_pkg::t_qent                    r_mem [rvg_pkg::FIFO_DEPTH];
    logic [rvg_pkg::FIFO_AW-1:0]       r_wr_ptr;
    logic [rvg_pkg::FIFO_AW-1:0]       r_rd_ptr;
    logic [rvg_pkg::FIFO_CNT_W-1:0]    r_count;
    logic                              w_push;
    logic                              w_pop;

    // Classify the command and keep only the fields it needs
    always_comb begin
        w_ent.payload = '0;
        case (i_s_tuser)
            rvg_pkg::CMD_LOAD: begin
                w_ent.op      = rvg_pkg::OP_LOAD;
                w_ent.payload = i_s_tdata[rvg_pkg::PAYLOAD_W-1:0];
            end
            rvg_pkg::CMD_TICK: begin
                w_ent.op      = rvg_pkg::OP_TICK;
                w_ent.payload = i_s_tdata[rvg_pkg::IN_DATA_W-1:rvg_pkg::PAYLOAD_W];
            end
            rvg_pkg::CMD_PLAY:    w_ent.op = rvg_pkg::OP_PLAY;
            rvg_pkg::CMD_RESTART: w_ent.op = rvg_pkg::OP_RESTART;
            rvg_pkg::CMD_PAUSE:   w_ent.op = rvg_pkg::OP_PAUSE;
            rvg_pkg::CMD_STOP:    w_ent.op = rvg_pkg::OP_STOP;
            default:              w_ent.op = rvg_pkg::OP_NONE;
        endcase
    end

    assign o_s_tready = (r_count != rvg_pkg::FIFO_CNT_W'(rvg_pkg::FIFO_DEPTH));
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = i_q_pop && (r_count != '0);
    assign o_q_valid  = (r_count != '0);
    assign o_q_ent    = r_mem[r_rd_ptr];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Hold queued requests
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_ent;
        end
    end

endmodule

// ===== rtl/rvg_back.sv =====
module rvg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rvg_pkg::t_cfg                 i_cfg,
    input  logic                          i_q_valid,
    input  rvg_pkg::t_qent                i_q_ent,
    output logic                          o_q_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rvg_pkg::OUT_W-1:0]     o_out_left,
    output logic [rvg_pkg::OUT_W-1:0]     o_out_right,
    output logic [1:0]                    o_play_state
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_RD0,
        S_RD1,
        S_RD2,
        S_LRP_L,
        S_LRP_R,
        S_GAIN_L,
        S_GAIN_R,
        S_FIN,
        S_EMIT
    } t_state;

    t_state                              r_state;
    logic [1:0]                          r_vs;
    logic [rvg_pkg::HEAD_W-1:0]          r_playhead;
    logic [rvg_pkg::IDX_W-1:0]           r_end_mark;
    logic                                r_go;
    logic                                r_idx_max;
    logic [rvg_pkg::PAYLOAD_W-1:0]       r_mix;
    logic [rvg_pkg::IDX_W-1:0]           r_dvd;
    logic [rvg_pkg::LEN_W-1:0]           r_dvsr;
    logic [rvg_pkg::LEN_W-1:0]           r_rem;
    logic [rvg_pkg::DIV_CNT_W-1:0]       r_cnt;
    logic [rvg_pkg::CLIP_AW-1:0]         r_i1;
    logic [rvg_pkg::FRAME_W-1:0]         r_fa;
    logic [rvg_pkg::FRAME_W-1:0]         r_fb;
    logic signed [rvg_pkg::PROD_W-1:0]   r_prod;
    logic signed [rvg_pkg::SUM_W-1:0]    r_sl;
    logic signed [rvg_pkg::SUM_W-1:0]    r_sr;
    logic [rvg_pkg::OUT_W-1:0]           r_ol;
    logic [rvg_pkg::OUT_W-1:0]           r_or;
    logic                                r_m_valid;
    logic [rvg_pkg::OUT_W-1:0]           r_m_left;
    logic [rvg_pkg::OUT_W-1:0]           r_m_right;
    logic [1:0]                          r_m_state;

    logic [rvg_pkg::LEN_W-1:0]           w_eff_len;
    logic [rvg_pkg::IDX_W-1:0]           w_idx;
    logic                                w_at_end;
    logic                                w_pop;
    logic                                w_out_free;
    logic [rvg_pkg::LEN_W:0]             w_div_t;
    logic [rvg_pkg::LEN_W-1:0]           w_rem_n;
    logic [rvg_pkg::LEN_W:0]             w_rem_inc;
    logic                                w_ram_we;
    logic [rvg_pkg::CLIP_AW-1:0]         w_ram_addr;
    logic [rvg_pkg::FRAME_W-1:0]         w_ram_rdata;
    logic signed [rvg_pkg::SMP_W:0]      w_diff_l;
    logic signed [rvg_pkg::SMP_W:0]      w_diff_r;
    logic signed [rvg_pkg::SMP_W:0]      w_term;
    logic signed [rvg_pkg::SUM_W-1:0]    w_sum_l;
    logic signed [rvg_pkg::SUM_W-1:0]    w_sum_r;
    logic signed [rvg_pkg::SUM_W-1:0]    w_ma;
    logic signed [rvg_pkg::LEN_W-1:0]    w_mb;
    logic signed [rvg_pkg::PROD_W-1:0]   w_mul;
    logic [rvg_pkg::OUT_W-1:0]           w_gained;

    // A zero clip length counts as one frame
    assign w_eff_len  = (i_cfg.clip_len == '0) ? rvg_pkg::LEN_W'(1) : i_cfg.clip_len;
    assign w_idx      = r_playhead[rvg_pkg::HEAD_W-1:rvg_pkg::FRAC_BITS];
    assign w_at_end   = (w_idx >= r_end_mark);
    assign w_pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop    = w_pop;
    assign w_out_free = !r_m_valid || i_m_tready;

    // One restoring division step: frame index modulo clip length
    assign w_div_t   = {r_rem, r_dvd[rvg_pkg::IDX_W-1]};
    assign w_rem_n   = (w_div_t >= {1'b0, r_dvsr}) ?
                       rvg_pkg::LEN_W'(w_div_t - {1'b0, r_dvsr}) :
                       w_div_t[rvg_pkg::LEN_W-1:0];
    assign w_rem_inc = {1'b0, r_rem} + 1'b1;

    // Clip memory port: load writes from idle, reads fetch both neighbor frames
    assign w_ram_we = w_pop && (i_q_ent.op == rvg_pkg::OP_LOAD);
    always_comb begin
        case (r_state)
            S_IDLE:  w_ram_addr = i_q_ent.payload[rvg_pkg::CLIP_AW-1:0];
            S_RD0:   w_ram_addr = r_rem[rvg_pkg::CLIP_AW-1:0];
            default: w_ram_addr = r_i1;
        endcase
    end

    rvg_ram #(
        .WIDTH (rvg_pkg::FRAME_W),
        .DEPTH (rvg_pkg::CLIP_FRAMES)
    ) u_clip_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (i_q_ent.payload[rvg_pkg::CLIP_AW +: rvg_pkg::FRAME_W]),
        .o_rdata (w_ram_rdata)
    );

    // Interpolation differences and accumulated sums
    assign w_diff_l = $signed({r_fb[rvg_pkg::SMP_W-1], r_fb[rvg_pkg::SMP_W-1:0]})
                    - $signed({r_fa[rvg_pkg::SMP_W-1], r_fa[rvg_pkg::SMP_W-1:0]});
    assign w_diff_r = $signed({r_fb[rvg_pkg::FRAME_W-1], r_fb[rvg_pkg::FRAME_W-1:rvg_pkg::SMP_W]})
                    - $signed({r_fa[rvg_pkg::FRAME_W-1], r_fa[rvg_pkg::FRAME_W-1:rvg_pkg::SMP_W]});
    assign w_term   = r_prod[rvg_pkg::FRAC_BITS +: (rvg_pkg::SMP_W + 1)];
    assign w_sum_l  = rvg_pkg::SUM_W'($signed(r_mix[rvg_pkg::MIX_W-1:0]))
                    + rvg_pkg::SUM_W'($signed(r_fa[rvg_pkg::SMP_W-1:0]))
                    + rvg_pkg::SUM_W'(w_term);
    assign w_sum_r  = rvg_pkg::SUM_W'($signed(r_mix[rvg_pkg::PAYLOAD_W-1:rvg_pkg::MIX_W]))
                    + rvg_pkg::SUM_W'($signed(r_fa[rvg_pkg::FRAME_W-1:rvg_pkg::SMP_W]))
                    + rvg_pkg::SUM_W'(w_term);

    // Shared multiplier: lerp fractions first, then the two gains
    always_comb begin
        case (r_state)
            S_LRP_L: begin
                w_ma = rvg_pkg::SUM_W'(w_diff_l);
                w_mb = $signed({5'd0, r_playhead[rvg_pkg::FRAC_BITS-1:0]});
            end
            S_LRP_R: begin
                w_ma = rvg_pkg::SUM_W'(w_diff_r);
                w_mb = $signed({5'd0, r_playhead[rvg_pkg::FRAC_BITS-1:0]});
            end
            S_GAIN_L: begin
                w_ma = r_sl;
                w_mb = $signed({1'b0, i_cfg.left_gain});
            end
            S_GAIN_R: begin
                w_ma = r_sr;
                w_mb = $signed({1'b0, i_cfg.right_gain});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mul    = w_ma * w_mb;
    assign w_gained = r_prod[rvg_pkg::GAIN_SHIFT +: rvg_pkg::OUT_W];

    // Sequencer, voice state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vs       <= rvg_pkg::VS_STOPPED;
            r_playhead <= '0;
            r_end_mark <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (r_state == S_EMIT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_ol <= '0;
                        r_or <= '0;
                        r_mix <= i_q_ent.payload;
                        r_sl <= rvg_pkg::SUM_W'($signed(i_q_ent.payload[rvg_pkg::MIX_W-1:0]));
                        r_sr <= rvg_pkg::SUM_W'($signed(
                                    i_q_ent.payload[rvg_pkg::PAYLOAD_W-1:rvg_pkg::MIX_W]));
                        case (i_q_ent.op)
                            rvg_pkg::OP_TICK: begin
                                if (r_vs == rvg_pkg::VS_PLAYING && w_at_end
                                        && !i_cfg.loop_en) begin
                                    r_vs    <= rvg_pkg::VS_STOPPED;
                                    r_go    <= 1'b0;
                                    r_state <= S_GAIN_L;
                                end else if (r_vs == rvg_pkg::VS_PLAYING) begin
                                    if (w_at_end) begin
                                        r_end_mark <= w_idx + rvg_pkg::IDX_W'(w_eff_len);
                                    end
                                    r_go      <= 1'b1;
                                    r_idx_max <= &w_idx;
                                    r_dvd     <= w_idx;
                                    r_dvsr    <= w_eff_len;
                                    r_rem     <= '0;
                                    r_cnt     <= rvg_pkg::DIV_CNT_W'(rvg_pkg::IDX_W - 1);
                                    r_state   <= S_DIV;
                                end else begin
                                    r_go    <= 1'b0;
                                    r_state <= S_GAIN_L;
                                end
                            end
                            rvg_pkg::OP_PLAY: begin
                                if (r_vs == rvg_pkg::VS_STOPPED) begin
                                    r_playhead <= '0;
                                    r_end_mark <= rvg_pkg::IDX_W'(w_eff_len);
                                end
                                r_vs    <= rvg_pkg::VS_PLAYING;
                                r_state <= S_EMIT;
                            end
                            rvg_pkg::OP_RESTART: begin
                                r_playhead <= '0;
                                r_end_mark <= rvg_pkg::IDX_W'(w_eff_len);
                                r_vs       <= rvg_pkg::VS_PLAYING;
                                r_state    <= S_EMIT;
                            end
                            rvg_pkg::OP_PAUSE: begin
                                if (r_vs == rvg_pkg::VS_PLAYING) begin
                                    r_vs <= rvg_pkg::VS_PAUSED;
                                end
                                r_state <= S_EMIT;
                            end
                            rvg_pkg::OP_STOP: begin
                                r_vs    <= rvg_pkg::VS_STOPPED;
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem <= w_rem_n;
                    r_dvd <= {r_dvd[rvg_pkg::IDX_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_RD0;
                    end
                end
                S_RD0: begin
                    // next frame wraps at the clip length, and at the index width
                    if (r_idx_max || (w_rem_inc == {1'b0, r_dvsr})) begin
                        r_i1 <= '0;
                    end else begin
                        r_i1 <= w_rem_inc[rvg_pkg::CLIP_AW-1:0];
                    end
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_fa    <= w_ram_rdata;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_fb    <= w_ram_rdata;
                    r_state <= S_LRP_L;
                end
                S_LRP_L: begin
                    r_prod  <= w_mul;
                    r_state <= S_LRP_R;
                end
                S_LRP_R: begin
                    r_prod  <= w_mul;
                    r_sl    <= w_sum_l;
                    r_state <= S_GAIN_L;
                end
                S_GAIN_L: begin
                    r_prod <= w_mul;
                    if (r_go) begin
                        r_sr <= w_sum_r;
                    end
                    r_state <= S_GAIN_R;
                end
                S_GAIN_R: begin
                    r_prod  <= w_mul;
                    r_ol    <= w_gained;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_or <= w_gained;
                    if (r_go) begin
                        r_playhead <= r_playhead + rvg_pkg::HEAD_W'(i_cfg.step_rate);
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_m_left  <= r_ol;
                        r_m_right <= r_or;
                        r_m_state <= r_vs;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_out_left   = r_m_left;
    assign o_out_right  = r_m_right;
    assign o_play_state = r_m_state;

endmodule

// ===== rtl/resampling_voice_with_gain_core.sv =====
// Stereo sample-playback voice. Each request on the input stream gives exactly one result
// on the output stream, in order. Load requests write one left/right frame into a
// 64K-frame clip memory; tick requests return one gained output frame, the incoming mix
// frame plus, while playing, a sample interpolated linearly between two clip frames at a
// 12-fractional-bit playhead; play, restart, pause and stop change the voice state. A
// four-entry request queue decouples the input stream from the sequencer, and an output
// register decouples the sequencer from the output stream. A tick while playing runs a
// bit-serial reduction of the frame index modulo the clip length, two single-port clip
// memory reads, and four passes through one shared multiplier. Write the configuration
// registers only while no request is in flight.
module resampling_voice_with_gain_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [rvg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rvg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Request stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // frame_address[15:0], left_sample[31:16], right_sample[47:32],
    // mix_left[71:48], mix_right[95:72]
    input  logic [rvg_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // command[2:0]
    input  logic [rvg_pkg::IN_USER_W-1:0]    i_s_tuser,
    // Result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // out_left[28:0], out_right[57:29], play_state[59:58], zero[63:60]
    output logic [rvg_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    rvg_pkg::t_cfg                r_cfg;
    logic                         w_q_valid;
    rvg_pkg::t_qent               w_q_ent;
    logic                         w_q_pop;
    logic [rvg_pkg::OUT_W-1:0]    w_out_left;
    logic [rvg_pkg::OUT_W-1:0]    w_out_right;
    logic [1:0]                   w_play_state;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_rate  <= rvg_pkg::RATE_W'(4096);
            r_cfg.left_gain  <= rvg_pkg::GAIN_W'(4096);
            r_cfg.right_gain <= rvg_pkg::GAIN_W'(4096);
            r_cfg.loop_en    <= 1'b0;
            r_cfg.clip_len   <= rvg_pkg::LEN_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rvg_pkg::CFG_STEP_RATE:  r_cfg.step_rate  <= i_cfg_wdata[rvg_pkg::RATE_W-1:0];
                rvg_pkg::CFG_LEFT_GAIN:  r_cfg.left_gain  <= i_cfg_wdata[rvg_pkg::GAIN_W-1:0];
                rvg_pkg::CFG_RIGHT_GAIN: r_cfg.right_gain <= i_cfg_wdata[rvg_pkg::GAIN_W-1:0];
                rvg_pkg::CFG_LOOP_EN:    r_cfg.loop_en    <= i_cfg_wdata[0];
                rvg_pkg::CFG_CLIP_LEN:   r_cfg.clip_len   <= i_cfg_wdata[rvg_pkg::LEN_W-1:0];
                default:                 r_cfg            <= r_cfg;
            endcase
        end
    end

    rvg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (w_q_valid),
        .o_q_ent    (w_q_ent),
        .i_q_pop    (w_q_pop)
    );

    rvg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (w_q_valid),
        .i_q_ent      (w_q_ent),
        .o_q_pop      (w_q_pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_out_left   (w_out_left),
        .o_out_right  (w_out_right),
        .o_play_state (w_play_state)
    );

    // Pack the result fields
    assign o_m_tdata = {4'd0, w_play_state, w_out_right, w_out_left};

endmodule
